FILE: hdl/rgbhsv_pkg.sv
package rgbhsv_pkg;

  localparam int unsigned RgbMax = 255;
  localparam int unsigned SvMax  = 1000;
  localparam int unsigned ChW    = 8;
  localparam int unsigned QuoW   = 8;

  // Reciprocal of RgbMax in fixed point. It is exact for any product below about 2^18,
  // which covers 255 * SvMax.
  localparam int unsigned    RecipShift = 26;
  localparam longint unsigned RgbRecip  =
    ((longint'(1) << RecipShift) + longint'(RgbMax) - 1) / longint'(RgbMax);
  localparam longint unsigned SvRecip   = longint'(SvMax) * RgbRecip;

  typedef enum logic [1:0] {
    SEC_RED   = 2'd0,
    SEC_GREEN = 2'd1,
    SEC_BLUE  = 2'd2
  } sector_e;

  // Scales a 0..255 value by SvMax/RgbMax with truncation, clamped to 1023.
  // The division is a multiplication by the fixed-point reciprocal and a shift.
  function automatic logic [9:0] scale_sv(input logic [ChW-1:0] x);
    logic [47:0] prod;
    logic [47:0] quo;
    begin
      prod = 48'(x) * 48'(SvRecip);
      quo  = prod >> RecipShift;
      if (quo > 48'd1023) begin
        scale_sv = 10'd1023;
      end else begin
        scale_sv = quo[9:0];
      end
    end
  endfunction

endpackage

FILE: hdl/rgb_to_hsv_convert_unit.sv
// RGB to HSV conversion, one item per clock.
// Throughput: one item per cycle; busy is tied low since the pipeline never stalls.
// The receiver cannot stall, so each result is shown for exactly one cycle.
// Reset clears only the valid bits of the pipeline; payload registers are not reset.
module rgb_to_hsv_convert_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [15:0] red_in_i,
  input  logic [15:0] green_in_i,
  input  logic [15:0] blue_in_i,
  output logic        done_o,
  output logic [8:0]  hue_o,
  output logic [9:0]  saturation_o,
  output logic [9:0]  brightness_o
);

  localparam int unsigned W = rgbhsv_pkg::ChW;

  assign busy = 1'b0;

  // Stage 1: channel bytes, maximum, minimum and sector.
  logic [W-1:0] r1_q, g1_q, b1_q, mx1_q, mn1_q;
  rgbhsv_pkg::sector_e sec1_q;
  logic         v1_q, v2_q, v3_q, v4_q, v5_q, v6_q;

  always_ff @(posedge clk_i) begin
    logic [W-1:0] r, g, b, mx, mn;
    r = red_in_i[15:8];
    g = green_in_i[15:8];
    b = blue_in_i[15:8];
    mx = r;
    if (g > mx) mx = g;
    if (b > mx) mx = b;
    mn = r;
    if (g < mn) mn = g;
    if (b < mn) mn = b;
    r1_q <= r; g1_q <= g; b1_q <= b;
    mx1_q <= mx; mn1_q <= mn;
    if (r == mx) sec1_q <= rgbhsv_pkg::SEC_RED;
    else if (g == mx) sec1_q <= rgbhsv_pkg::SEC_GREEN;
    else sec1_q <= rgbhsv_pkg::SEC_BLUE;
  end

  // Stage 2: differences feeding the four dividers.
  logic [W-1:0] d2_q, mx2_q;
  logic [W-1:0] dr2_q, dg2_q, db2_q;
  rgbhsv_pkg::sector_e sec2_q;
  always_ff @(posedge clk_i) begin
    d2_q  <= mx1_q - mn1_q;
    mx2_q <= mx1_q;
    dr2_q <= mx1_q - r1_q;
    dg2_q <= mx1_q - g1_q;
    db2_q <= mx1_q - b1_q;
    sec2_q <= sec1_q;
  end

  // Divider guards: a zero denominator is replaced by one; the result is masked later.
  logic [W-1:0] dden, mden;
  assign dden = (d2_q == '0) ? W'(1) : d2_q;
  assign mden = (mx2_q == '0) ? W'(1) : mx2_q;

  logic [W-1:0] s4, rc4, gc4, bc4;
  rgbhsv_div u_div_s (.clk_i, .num_i(16'(d2_q) * 16'(rgbhsv_pkg::RgbMax)), .den_i(mden),
                      .quo_o(s4));
  rgbhsv_div u_div_r (.clk_i, .num_i(16'(dr2_q) * 16'(rgbhsv_pkg::RgbMax)), .den_i(dden),
                      .quo_o(rc4));
  rgbhsv_div u_div_g (.clk_i, .num_i(16'(dg2_q) * 16'(rgbhsv_pkg::RgbMax)), .den_i(dden),
                      .quo_o(gc4));
  rgbhsv_div u_div_b (.clk_i, .num_i(16'(db2_q) * 16'(rgbhsv_pkg::RgbMax)), .den_i(dden),
                      .quo_o(bc4));

  // Side band delayed alongside the two divider stages.
  logic [W-1:0] mx3_q, mx4_q;
  logic         z3_q, z4_q;
  rgbhsv_pkg::sector_e sec3_q, sec4_q;
  always_ff @(posedge clk_i) begin
    mx3_q <= mx2_q;  mx4_q <= mx3_q;
    z3_q  <= (mx2_q == '0) || (d2_q == '0);
    z4_q  <= z3_q;
    sec3_q <= sec2_q; sec4_q <= sec3_q;
  end

  // Stage 5: signed sector difference times 60.
  logic signed [15:0] hm5_q;
  logic [8:0]         base5_q;
  logic [W-1:0]       s5_q, mx5_q;
  logic               hz5_q;
  always_ff @(posedge clk_i) begin
    logic signed [9:0] df;
    unique case (sec4_q)
      rgbhsv_pkg::SEC_RED: begin
        df = 10'(bc4) - 10'(gc4); base5_q <= 9'd0;
      end
      rgbhsv_pkg::SEC_GREEN: begin
        df = 10'(rc4) - 10'(bc4); base5_q <= 9'd120;
      end
      default: begin
        df = 10'(gc4) - 10'(rc4); base5_q <= 9'd240;
      end
    endcase
    hm5_q <= 16'(df) * 16'sd60;
    s5_q  <= z4_q ? '0 : s4;
    hz5_q <= z4_q || (s4 == '0);
    mx5_q <= mx4_q;
  end

  // Stage 6: divide by 255 toward zero, wrap, scale outputs.
  logic [8:0] h6_q;
  logic [9:0] s6_q, v6p_q;
  always_ff @(posedge clk_i) begin
    logic        neg;
    logic [15:0] mag;
    logic [15:0] q;
    logic signed [10:0] h;
    neg = hm5_q[15];
    mag = neg ? 16'(-hm5_q) : 16'(hm5_q);
    q   = 16'((32'(mag) * 32'd257 + 32'd257) >> 16);
    if (32'(q) * 32'(rgbhsv_pkg::RgbMax) > 32'(mag)) q = q - 16'd1;
    h = 11'(base5_q) + (neg ? -11'(q) : 11'(q));
    if (h < 0) h = h + 11'sd360;
    h6_q  <= hz5_q ? 9'd0 : 9'(h);
    s6_q  <= rgbhsv_pkg::scale_sv(s5_q);
    v6p_q <= rgbhsv_pkg::scale_sv(mx5_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      {v1_q, v2_q, v3_q, v4_q, v5_q, v6_q} <= '0;
    end else begin
      v1_q <= start;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
      v6_q <= v5_q;
    end
  end

  assign done_o       = v6_q;
  assign hue_o        = h6_q;
  assign saturation_o = s6_q;
  assign brightness_o = v6p_q;

endmodule

FILE: hdl/rgbhsv_div.sv
// Pipelined restoring divider: quotient = num / den for num <= den * 255.
// Operand widths are fixed; four quotient bits are resolved per stage.
module rgbhsv_div (
  input  logic                            clk_i,
  input  logic [rgbhsv_pkg::ChW+7:0]      num_i,
  input  logic [rgbhsv_pkg::ChW-1:0]      den_i,
  output logic [rgbhsv_pkg::QuoW-1:0]     quo_o
);

  localparam int unsigned NW = rgbhsv_pkg::ChW + 8;
  localparam int Steps = 4;

  // Dividend is at most 255*255 < 2^16, quotient at most 255 (8 bits).
  // Two stages, four quotient bits each.
  logic [NW-1:0]  rem_q;
  logic [7:0]     den_q;
  logic [7:0]     quo_q [2];
  logic [NW-1:0]  rem_d;
  logic [7:0]     quo_d [2];

  always_comb begin
    logic [NW-1:0] r;
    logic [7:0]    qv;
    r  = num_i;
    qv = '0;
    for (int k = 7; k >= 8 - Steps; k--) begin
      if (r >= ({8'd0, den_i} << k)) begin
        r = r - ({8'd0, den_i} << k);
        qv[k] = 1'b1;
      end
    end
    rem_d    = r;
    quo_d[0] = qv;
  end

  always_comb begin
    logic [NW-1:0] r;
    logic [7:0]    qv;
    r  = rem_q;
    qv = quo_q[0];
    for (int k = 7 - Steps; k >= 0; k--) begin
      if (r >= ({8'd0, den_q} << k)) begin
        r = r - ({8'd0, den_q} << k);
        qv[k] = 1'b1;
      end
    end
    quo_d[1] = qv;
  end

  always_ff @(posedge clk_i) begin
    rem_q    <= rem_d;
    quo_q[0] <= quo_d[0];
    den_q    <= den_i;
    quo_q[1] <= quo_d[1];
  end

  assign quo_o = quo_q[1];

endmodule

FILE: hdl/rgbhsv_checker.sv
module rgbhsv_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       start,
  input logic       busy,
  input logic       done_o,
  input logic [8:0] hue_o,
  input logic [9:0] saturation_o,
  input logic [9:0] brightness_o
);

  a_busy_low: assert property (@(posedge clk_i) disable iff (!rst_ni) !busy)
    else $error("busy raised");
  a_done_lat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start |-> ##6 done_o) else $error("result missing");
  a_hue_rng: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> hue_o < 9'd360) else $error("hue out of range");
  a_sat_le_v: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> saturation_o <= 10'd1000) else $error("saturation out of range");
  a_grey: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && saturation_o == '0 |-> hue_o == '0) else $error("hue on grey");

endmodule

bind rgb_to_hsv_convert_unit rgbhsv_checker u_chk (.*);
